### design/ctm_pkg.sv
// shared constants and codes for the command trie matcher
`default_nettype none

package ctm_pkg;

  // field widths fixed by the item format
  localparam int CHAR_W   = 8;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int CMD_ID_W = 8;

  // parameter defaults
  localparam int NODE_COUNT_DEF = 64;
  localparam int ID_WIDTH_DEF   = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd2;
  localparam logic [OP_W-1:0] OP_MATCH   = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOFIN   = 3'd4;

endpackage

`default_nettype wire

### design/ctm_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ctm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/command_trie_matcher_core.sv
// command trie matcher: first-child / next-sibling trie in a node ram
`default_nettype none

// Keeps a trie of command words in a pool of NODE_COUNT nodes held in one
// ram; node 0 is the null link, so nodes are allocated from 1 upward and
// never freed except by a clear item. Every item gives exactly one result
// item (status and matched id). Items are handled one at a time by a small
// sequencer around the node ram, whose read data arrives in the cycle after
// the address, so the sibling walk visits one node per cycle.
// Clear, restart, unused codes, insert after a failure, finish after a
// failure or with an empty word, match on an empty trie and the first
// insert into an empty trie go straight to the result. Insert and match
// read the cursor record if the cursor is below the root and walk the
// sibling list; insert appends a new node when none matches. Finish reads
// the cursor record and writes it back as terminal. The result then loads
// the output register, and the next item is taken in the cycle after that
// load, even while the output register still waits on out_stall. There is
// no clearing pass after reset: the pool is only read at nodes that were
// allocated and written in full.
module command_trie_matcher_core #(
  parameter int NODE_COUNT = ctm_pkg::NODE_COUNT_DEF,
  parameter int ID_WIDTH   = ctm_pkg::ID_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // item input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ctm_pkg::OP_W-1:0]      in_operation,
  input  wire logic [ctm_pkg::CHAR_W-1:0]    in_character,
  input  wire logic [ctm_pkg::CMD_ID_W-1:0]  in_command_id,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ctm_pkg::STATUS_W-1:0]  out_status,
  output logic      [ctm_pkg::CMD_ID_W-1:0]  out_matched_id
);

  import ctm_pkg::*;

  // node index width and free pointer width (free pointer can reach NODE_COUNT)
  localparam int AW   = $clog2(NODE_COUNT);
  localparam int NF_W = AW + 1;
  localparam logic [NF_W-1:0] POOL_END = NF_W'(NODE_COUNT);

  // one node record per ram word
  typedef struct packed {
    logic [CHAR_W-1:0]   ch;
    logic [AW-1:0]       child;
    logic [AW-1:0]       sibling;
    logic                terminal;
    logic [ID_WIDTH-1:0] cmd;
  } node_t;

  localparam int REC_W = $bits(node_t);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for an item
    S_HEAD = 5'b00010,  // cursor record on read data
    S_WALK = 5'b00100,  // sibling list node on read data
    S_NEWN = 5'b01000,  // link written, now write the new node
    S_DONE = 5'b10000   // result waiting for the output register
  } state_t;

  state_t state_r, state_nxt;

  // trie bookkeeping
  logic [AW-1:0]   root_head_r, root_head_nxt;
  logic [NF_W-1:0] next_free_r, next_free_nxt;
  logic [AW-1:0]   ins_cur_r, ins_cur_nxt;
  logic            ins_fail_r, ins_fail_nxt;
  logic [AW-1:0]   match_cur_r, match_cur_nxt;

  // current item and walk position
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [AW-1:0]       node_r, node_nxt;

  // pending result and output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [CMD_ID_W-1:0] res_id_r, res_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CMD_ID_W-1:0] out_id_r, out_id_nxt;

  // node ram port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  node_t            mem_wrec;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [REC_W-1:0] mem_rdata;
  node_t            rd;

  logic [ID_WIDTH-1:0] id_in;
  logic [CMD_ID_W-1:0] id_hit;
  logic                pool_full;
  logic                out_free;
  logic [AW-1:0]       nf_idx;

  assign rd       = node_t'(mem_rdata);
  assign nf_idx   = next_free_r[AW-1:0];
  assign pool_full = (next_free_r >= POOL_END);
  assign out_free = !out_valid_r || !out_stall;

  // fit the 8-bit command id to the stored id width and back
  if (ID_WIDTH > CMD_ID_W) begin : g_id_wide
    assign id_in  = {{(ID_WIDTH-CMD_ID_W){1'b0}}, in_command_id};
    assign id_hit = rd.cmd[CMD_ID_W-1:0];
  end else if (ID_WIDTH == CMD_ID_W) begin : g_id_same
    assign id_in  = in_command_id;
    assign id_hit = rd.cmd;
  end else begin : g_id_narrow
    assign id_in  = in_command_id[ID_WIDTH-1:0];
    assign id_hit = {{(CMD_ID_W-ID_WIDTH){1'b0}}, rd.cmd};
  end

  ctm_ram #(
    .WIDTH(REC_W),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wrec),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // only one item is in flight, so a node written by one step is read
  // only in a later cycle: no same-entry overlap to forward
  always_comb begin
    state_nxt      = state_r;
    root_head_nxt  = root_head_r;
    next_free_nxt  = next_free_r;
    ins_cur_nxt    = ins_cur_r;
    ins_fail_nxt   = ins_fail_r;
    match_cur_nxt  = match_cur_r;
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    id_nxt         = id_r;
    node_nxt       = node_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wrec       = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_operation;
          ch_nxt         = in_character;
          id_nxt         = id_in;
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          state_nxt      = S_DONE;
          unique case (in_operation)
            OP_CLEAR: begin
              root_head_nxt = '0;
              next_free_nxt = NF_W'(1);
              ins_cur_nxt   = '0;
              ins_fail_nxt  = 1'b0;
              match_cur_nxt = '0;
            end
            OP_INSERT: begin
              priority if (ins_fail_r) begin
                res_status_nxt = ST_FULL;
              end else if (ins_cur_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = ins_cur_r;
                state_nxt = S_HEAD;
              end else if (root_head_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = root_head_r;
                node_nxt  = root_head_r;
                state_nxt = S_WALK;
              end else if (pool_full) begin
                ins_fail_nxt   = 1'b1;
                res_status_nxt = ST_FULL;
              end else begin
                // empty trie: first node becomes the root list
                mem_we        = 1'b1;
                mem_waddr     = nf_idx;
                mem_wrec.ch   = in_character;
                root_head_nxt = nf_idx;
                ins_cur_nxt   = nf_idx;
                next_free_nxt = next_free_r + NF_W'(1);
              end
            end
            OP_FINISH: begin
              priority if (ins_fail_r) begin
                // abandon the word
                ins_fail_nxt   = 1'b0;
                ins_cur_nxt    = '0;
                res_status_nxt = ST_FULL;
              end else if (ins_cur_r == '0) begin
                res_status_nxt = ST_NOFIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ins_cur_r;
                state_nxt = S_HEAD;
              end
            end
            OP_MATCH: begin
              priority if (match_cur_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = match_cur_r;
                state_nxt = S_HEAD;
              end else if (root_head_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = root_head_r;
                node_nxt  = root_head_r;
                state_nxt = S_WALK;
              end else begin
                res_status_nxt = ST_NOMATCH;
              end
            end
            OP_RESTART: begin
              match_cur_nxt = '0;
            end
            default: begin
              // unused codes change nothing
            end
          endcase
        end
      end

      S_HEAD: begin
        priority if (op_r == OP_FINISH) begin
          mem_we            = 1'b1;
          mem_waddr         = ins_cur_r;
          mem_wrec          = rd;
          mem_wrec.terminal = 1'b1;
          mem_wrec.cmd      = id_r;
          ins_cur_nxt       = '0;
          res_status_nxt    = ST_OK;
          state_nxt         = S_DONE;
        end else if (rd.child != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rd.child;
          node_nxt  = rd.child;
          state_nxt = S_WALK;
        end else if (op_r == OP_MATCH) begin
          res_status_nxt = ST_NOMATCH;
          state_nxt      = S_DONE;
        end else if (pool_full) begin
          ins_fail_nxt   = 1'b1;
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          // no children yet: hang the new node under the cursor
          mem_we         = 1'b1;
          mem_waddr      = ins_cur_r;
          mem_wrec       = rd;
          mem_wrec.child = nf_idx;
          state_nxt      = S_NEWN;
        end
      end

      S_WALK: begin
        priority if (rd.ch == ch_r) begin
          state_nxt      = S_DONE;
          res_status_nxt = ST_OK;
          if (op_r == OP_MATCH) begin
            if (rd.terminal) begin
              res_status_nxt = ST_MATCH;
              res_id_nxt     = id_hit;
              match_cur_nxt  = '0;
            end else begin
              match_cur_nxt = node_r;
            end
          end else begin
            ins_cur_nxt = node_r;
          end
        end else if (rd.sibling != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rd.sibling;
          node_nxt  = rd.sibling;
        end else if (op_r == OP_MATCH) begin
          res_status_nxt = ST_NOMATCH;
          state_nxt      = S_DONE;
        end else if (pool_full) begin
          ins_fail_nxt   = 1'b1;
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          // append at the end of the sibling list
          mem_we           = 1'b1;
          mem_waddr        = node_r;
          mem_wrec         = rd;
          mem_wrec.sibling = nf_idx;
          state_nxt        = S_NEWN;
        end
      end

      S_NEWN: begin
        mem_we         = 1'b1;
        mem_waddr      = nf_idx;
        mem_wrec.ch    = ch_r;
        ins_cur_nxt    = nf_idx;
        next_free_nxt  = next_free_r + NF_W'(1);
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_head_r <= '0;
      next_free_r <= NF_W'(1);
      ins_cur_r   <= '0;
      ins_fail_r  <= 1'b0;
      match_cur_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_head_r <= root_head_nxt;
      next_free_r <= next_free_nxt;
      ins_cur_r   <= ins_cur_nxt;
      ins_fail_r  <= ins_fail_nxt;
      match_cur_r <= match_cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ch_r         <= ch_nxt;
    id_r         <= id_nxt;
    node_r       <= node_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_matched_id = out_id_r;

  // free pointer stays within 1 .. NODE_COUNT
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r != '0) && (next_free_r <= POOL_END))
    else $error("free pointer out of range");

  // an insert failure only ever happens on a full pool
  a_fail_full: assert property (@(posedge clk) disable iff (!rst_n)
    ins_fail_r |-> pool_full)
    else $error("insert failure without full pool");

  // cursors always point at allocated nodes
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, ins_cur_r} < next_free_r) && ({1'b0, match_cur_r} < next_free_r))
    else $error("cursor beyond allocated nodes");

  // a result waiting for the output register touches no memory
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (!mem_we && !mem_re))
    else $error("memory access while result pending");

  // a walk step always follows a read issued in the cycle before
  a_walk_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> $past(mem_re))
    else $error("walk step without read");

endmodule

`default_nettype wire
